// ----- src/abjsc_pkg.sv -----
// Shared types, constants and helper functions for the A/B journal slot checker.
// Depends on nothing; imported by ab_journal_slot_checker.
package abjsc_pkg;

  // Header layout and field values expected in a committed slot.
  localparam int unsigned HeaderBytes = 32;
  localparam int unsigned HdrIdxW     = $clog2(HeaderBytes);
  localparam int unsigned PosW        = 13;
  localparam int unsigned LenW        = 12;
  localparam int unsigned UnitIdW     = 16;
  localparam int unsigned SeqW        = 32;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 16;

  localparam logic [31:0]     MagicWord   = 32'h4e33_3231;
  localparam logic [15:0]     VersionWord = 16'd1;
  localparam logic [31:0]     CommitWord  = 32'h4354_4d21;
  localparam logic [31:0]     CrcPoly     = 32'hedb8_8320;
  localparam logic [31:0]     CrcInit     = 32'hffff_ffff;
  localparam logic [PosW-1:0] PosMax      = {PosW{1'b1}};

  typedef enum logic [2:0] {
    FAULT_OK     = 3'd0,
    FAULT_HEADER = 3'd1,
    FAULT_LENGTH = 3'd2,
    FAULT_CRC    = 3'd3,
    FAULT_SHORT  = 3'd4
  } fault_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_UNIT_ID     = 1'b0,
    REG_PAYLOAD_CAP = 1'b1
  } cfg_reg_e;

  // One byte of the reflected CRC-32, least significant bit first.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

  // Serial-number comparison: x is newer than y when (x - y) mod 2^32 is in 1 .. 2^31-1.
  function automatic logic seq_newer(input logic [SeqW-1:0] x, input logic [SeqW-1:0] y);
    logic [SeqW-1:0] d;
    d = x - y;
    return (d != '0) && !d[SeqW-1];
  endfunction

endpackage

// ----- src/ab_journal_slot_checker.sv -----
// Top level of the A/B journal slot checker: header capture, CRC-32, verdict and slot records.
// Depends on abjsc_pkg for constants, fault codes and the CRC and sequence helpers.
//
// Usage
// -----
// The byte image of one journal slot streams in on the input channel, one byte per
// transfer: the 32-byte little-endian header first, then the payload. last_byte_i marks
// the final byte of a slot. A transfer happens at a rising edge where in_valid_i is high
// and in_stall_o is low. Bytes without last_byte_i produce no result; the last byte
// produces exactly one result transfer carrying the verdict for that slot and the A/B
// selection derived from both stored slot records (newest slot, slot to overwrite next
// and the next sequence number, which never takes the value zero).
// Latency: the result is presented on the output channel in the cycle after the last
// byte is taken. Throughput: one byte per cycle while in_stall_o is low, with no gaps
// between slots; each payload byte is folded into the CRC by a single byte-wide update stage.
// The output is a single register stage. While a result waits and out_stall_i is high,
// in_stall_o is raised and the input is held off; as soon as the result is taken (or
// is not stalled) a new byte can be accepted in the same cycle.
// Reset (rst_ni low, asynchronous) returns the stream to its start, sets the CRC to all
// ones, marks both slot records invalid, sets unit_id to 0 and payload_capacity to 4064.
// The configuration channel is always ready; it should only be written while idle.
module ab_journal_slot_checker
  import abjsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Byte stream in
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                slot_index_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  // Verdict out
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                result_slot_o,
  output logic                slot_valid_o,
  output logic [2:0]          fault_code_o,
  output logic [SeqW-1:0]     slot_sequence_o,
  output logic [LenW-1:0]     payload_length_o,
  output logic                any_valid_o,
  output logic                newest_slot_o,
  output logic                write_slot_o,
  output logic [SeqW-1:0]     write_sequence_o
);

  // Configuration registers.
  logic [UnitIdW-1:0] unit_id_q;
  logic [LenW-1:0]    payload_cap_q;

  // Stream state.
  logic [PosW-1:0] pos_q, pos_d;
  logic [31:0]     crc_q, crc_d;
  logic [7:0]      header_q [HeaderBytes];

  // Stored slot records.
  logic [1:0]      rec_valid_q, rec_valid_d;
  logic [SeqW-1:0] rec_seq_q [2];
  logic [SeqW-1:0] rec_seq_d [2];

  // Result register.
  logic            out_valid_q;
  logic            res_slot_q;
  logic            res_valid_q;
  fault_e          res_fault_q;
  logic [SeqW-1:0] res_seq_q;
  logic [LenW-1:0] res_len_q;
  logic            res_any_q;
  logic            res_newest_q;
  logic            res_wslot_q;
  logic [SeqW-1:0] res_wseq_q;

  logic in_xfer;
  logic verdict;

  // The input is held off only while a finished result is waiting and stalled.
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_xfer     = in_valid_i & ~in_stall_o;
  assign verdict     = in_xfer & last_byte_i;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_id_q     <= '0;
      payload_cap_q <= LenW'(4064);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_UNIT_ID:     unit_id_q     <= cfg_data_i[UnitIdW-1:0];
        REG_PAYLOAD_CAP: payload_cap_q <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Header fields, taken from the captured header bytes
  // ---------------------------------------------------------------------------
  logic [31:0] hdr_magic, hdr_seq, hdr_len, hdr_crc, hdr_commit;
  logic [15:0] hdr_version, hdr_size, hdr_unit;

  assign hdr_magic   = {header_q[3],  header_q[2],  header_q[1],  header_q[0]};
  assign hdr_version = {header_q[5],  header_q[4]};
  assign hdr_size    = {header_q[7],  header_q[6]};
  assign hdr_unit    = {header_q[9],  header_q[8]};
  assign hdr_seq     = {header_q[15], header_q[14], header_q[13], header_q[12]};
  assign hdr_len     = {header_q[19], header_q[18], header_q[17], header_q[16]};
  assign hdr_crc     = {header_q[23], header_q[22], header_q[21], header_q[20]};
  assign hdr_commit  = {header_q[27], header_q[26], header_q[25], header_q[24]};

  // ---------------------------------------------------------------------------
  // Per-byte work: header capture, CRC update, position count
  // ---------------------------------------------------------------------------
  logic            in_header;
  logic [32:0]     payload_end;
  logic            in_payload;
  logic [PosW-1:0] count;
  logic [31:0]     crc_next;

  assign in_header   = pos_q < PosW'(HeaderBytes);
  // End of the payload measured from the start of the stream; 33 bits so that a
  // corrupt length near 2^32 does not wrap.
  assign payload_end = 33'(HeaderBytes) + {1'b0, hdr_len};
  assign in_payload  = !in_header && ({20'd0, pos_q} < payload_end);
  assign count       = (pos_q < PosMax) ? pos_q + 1'b1 : PosMax;
  assign crc_next    = in_payload ? crc32_byte(crc_q, data_byte_i) : crc_q;

  // Header bytes need no reset: the verdict looks at them only once the whole
  // header of the current stream has arrived.
  always_ff @(posedge clk_i) begin
    if (in_xfer && in_header) begin
      header_q[pos_q[HdrIdxW-1:0]] <= data_byte_i;
    end
  end

  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    if (in_xfer) begin
      pos_d = last_byte_i ? '0 : count;
      crc_d = last_byte_i ? CrcInit : crc_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= CrcInit;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Verdict on the last byte. The checks run in priority order: a stream that
  // ended inside the header, then the header fields, then the length against the
  // capacity, then a payload that was cut short, then the CRC.
  // ---------------------------------------------------------------------------
  fault_e fault;
  logic   hdr_ok;
  logic   slot_ok;

  assign hdr_ok = (hdr_magic == MagicWord) && (hdr_version == VersionWord) &&
                  (hdr_size == 16'(HeaderBytes)) && (hdr_unit == unit_id_q) &&
                  (hdr_commit == CommitWord);

  always_comb begin
    if (count < PosW'(HeaderBytes)) begin
      fault = FAULT_SHORT;
    end else if (!hdr_ok) begin
      fault = FAULT_HEADER;
    end else if (hdr_len > {20'd0, payload_cap_q}) begin
      fault = FAULT_LENGTH;
    end else if ({20'd0, count} < payload_end) begin
      fault = FAULT_SHORT;
    end else if ((crc_next ^ CrcInit) != hdr_crc) begin
      fault = FAULT_CRC;
    end else begin
      fault = FAULT_OK;
    end
  end

  assign slot_ok = (fault == FAULT_OK);

  // ---------------------------------------------------------------------------
  // Slot records and the A/B selection, worked out from the updated records
  // ---------------------------------------------------------------------------
  logic            b_newer;
  logic            newest;
  logic            wslot;
  logic [SeqW-1:0] wbase;
  logic [SeqW-1:0] wseq;

  always_comb begin
    rec_valid_d = rec_valid_q;
    rec_seq_d   = rec_seq_q;
    rec_valid_d[slot_index_i] = slot_ok;
    rec_seq_d[slot_index_i]   = slot_ok ? hdr_seq : '0;
  end

  assign b_newer = seq_newer(rec_seq_d[1], rec_seq_d[0]);

  always_comb begin
    newest = rec_valid_d[1] && (!rec_valid_d[0] || b_newer);
    if (rec_valid_d[0] && (!rec_valid_d[1] || !b_newer)) begin
      wslot = 1'b1;
      wbase = rec_seq_d[0];
    end else if (rec_valid_d[1]) begin
      wslot = 1'b0;
      wbase = rec_seq_d[1];
    end else begin
      wslot = 1'b0;
      wbase = '0;
    end
    // Sequence zero is reserved, so the count skips from all ones straight to one.
    wseq = wbase + 1'b1;
    if (wseq == '0) begin
      wseq = SeqW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_valid_q <= '0;
      rec_seq_q   <= '{default: '0};
    end else if (verdict) begin
      rec_valid_q <= rec_valid_d;
      rec_seq_q   <= rec_seq_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (verdict) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (verdict) begin
      res_slot_q   <= slot_index_i;
      res_valid_q  <= slot_ok;
      res_fault_q  <= fault;
      res_seq_q    <= slot_ok ? hdr_seq : '0;
      res_len_q    <= slot_ok ? hdr_len[LenW-1:0] : '0;
      res_any_q    <= |rec_valid_d;
      res_newest_q <= newest;
      res_wslot_q  <= wslot;
      res_wseq_q   <= wseq;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_slot_o    = res_slot_q;
  assign slot_valid_o     = res_valid_q;
  assign fault_code_o     = res_fault_q;
  assign slot_sequence_o  = res_seq_q;
  assign payload_length_o = res_len_q;
  assign any_valid_o      = res_any_q;
  assign newest_slot_o    = res_newest_q;
  assign write_slot_o     = res_wslot_q;
  assign write_sequence_o = res_wseq_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_valid_matches_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (slot_valid_o == (fault_code_o == FAULT_OK)))
    else $error("slot_valid disagrees with fault code");

  a_invalid_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !slot_valid_o) |-> (slot_sequence_o == '0 && payload_length_o == '0))
    else $error("invalid verdict carries a sequence or length");

  a_ab_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && any_valid_o) |-> (write_slot_o != newest_slot_o))
    else $error("write slot equals newest slot");

  a_wseq_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (write_sequence_o != '0))
    else $error("next sequence is zero");

  a_stream_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    verdict |=> (pos_q == '0 && crc_q == CrcInit && out_valid_o))
    else $error("stream state not restarted after last byte");

endmodule

// ----- test/ab_journal_slot_checker_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the A/B journal slot checker: directed slot images, then random traffic.
// Depends on abjsc_pkg and ab_journal_slot_checker; it needs no other file.
module ab_journal_slot_checker_tb;
  import abjsc_pkg::*;

  // The slowest correct run is some 1070 byte transfers plus sender gaps and output stalls
  // on each verdict, even if every byte closed a stream. The limit is many times that.
  localparam int unsigned CycleLimit = 50_000;

  // One verdict as it leaves the block, one member per output field.
  typedef struct packed {
    logic            slot;
    logic            ok;
    fault_e          fault;
    logic [SeqW-1:0] seq;
    logic [LenW-1:0] len;
    logic            any;
    logic            newest;
    logic            wslot;
    logic [SeqW-1:0] wseq;
  } verdict_t;

  // The fields of a slot header as the stimulus builds it. crc_flip is XORed into the
  // correct payload CRC, so that a non-zero value gives a CRC mismatch.
  typedef struct {
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] hsize;
    logic [15:0] unit;
    logic [31:0] seq;
    logic [31:0] len;
    logic [31:0] crc_flip;
    logic [31:0] commit;
  } header_t;

  // Clock, reset and every input of the block start at known values.
  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_valid_i  = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i   = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic                slot_index_i = 1'b0;
  logic [7:0]          data_byte_i  = '0;
  logic                last_byte_i  = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic                result_slot_o;
  logic                slot_valid_o;
  logic [2:0]          fault_code_o;
  logic [SeqW-1:0]     slot_sequence_o;
  logic [LenW-1:0]     payload_length_o;
  logic                any_valid_o;
  logic                newest_slot_o;
  logic                write_slot_o;
  logic [SeqW-1:0]     write_sequence_o;

  ab_journal_slot_checker dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .slot_index_i     (slot_index_i),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_slot_o    (result_slot_o),
    .slot_valid_o     (slot_valid_o),
    .fault_code_o     (fault_code_o),
    .slot_sequence_o  (slot_sequence_o),
    .payload_length_o (payload_length_o),
    .any_valid_o      (any_valid_o),
    .newest_slot_o    (newest_slot_o),
    .write_slot_o     (write_slot_o),
    .write_sequence_o (write_sequence_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------------------
  // Shadow state of the block. It mirrors what the hardware should hold after every byte
  // transfer and every register write, and starts from the reset values.
  // ---------------------------------------------------------------------------------------
  logic [PosW-1:0]    stream_pos    = '0;
  logic [7:0]         header_shadow [HeaderBytes];
  logic [31:0]        crc_shadow    = CrcInit;
  logic               slot_live [2] = '{1'b0, 1'b0};
  logic [SeqW-1:0]    slot_seq [2]  = '{'0, '0};
  logic [UnitIdW-1:0] cfg_unit      = '0;
  logic [LenW-1:0]    cfg_cap       = LenW'(4064);

  verdict_t    verdicts_due [$];  // verdicts predicted but not yet seen on the output
  logic [7:0]  slot_image [$];    // the byte image that the next stream will carry
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  bit          gaps_on    = 1'b1;

  // Little-endian reads from the captured header.
  function automatic logic [15:0] hdr_half(input int unsigned at);
    return {header_shadow[at + 1], header_shadow[at]};
  endfunction

  function automatic logic [31:0] hdr_word(input int unsigned at);
    return {hdr_half(at + 2), hdr_half(at)};
  endfunction

  // Bit-serial reflected CRC-32: each data bit, least significant first, is folded into
  // the feedback taken from the bottom of the register.
  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ data[i]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Sequence x is ahead of y when the forward distance is non-zero and below half the range.
  function automatic logic seq_is_ahead(input logic [SeqW-1:0] x, input logic [SeqW-1:0] y);
    logic [SeqW-1:0] gap;
    gap = x - y;
    return (gap != '0) && !gap[SeqW-1];
  endfunction

  // Advances the shadow state by one accepted byte. On the last byte of a stream it returns
  // 1 and hands back the verdict that the block must produce for it.
  function automatic logic judge_byte(input logic slot, input logic [7:0] data,
                                      input logic last, output verdict_t v);
    logic [PosW-1:0] pos;
    logic [PosW-1:0] count;
    logic [SeqW-1:0] wseq;
    logic            a_live;
    logic            b_live;
    logic            b_ahead;
    fault_e          fault;
    v   = '0;
    pos = stream_pos;
    // Header bytes are captured by position; payload bytes feed the CRC until the length
    // taken from the header is used up, and anything after that is ignored.
    if (pos < PosW'(HeaderBytes)) begin
      header_shadow[pos[HdrIdxW-1:0]] = data;
    end else if (64'(pos) < 64'(HeaderBytes) + 64'(hdr_word(16))) begin
      crc_shadow = crc_step(crc_shadow, data);
    end
    // The position counter sticks at its maximum rather than wrapping onto the header.
    count = (pos == PosMax) ? pos : pos + 1'b1;
    if (!last) begin
      stream_pos = count;
      return 1'b0;
    end

    // Faults in order of precedence: an incomplete header, a header field, the length
    // against capacity, a payload cut short, and only then the CRC.
    if (count < PosW'(HeaderBytes)) begin
      fault = FAULT_SHORT;
    end else if (hdr_word(0) != MagicWord || hdr_half(4) != VersionWord ||
                 hdr_half(6) != 16'(HeaderBytes) || hdr_half(8) != cfg_unit ||
                 hdr_word(24) != CommitWord) begin
      fault = FAULT_HEADER;
    end else if (hdr_word(16) > 32'(cfg_cap)) begin
      fault = FAULT_LENGTH;
    end else if (64'(count) < 64'(HeaderBytes) + 64'(hdr_word(16))) begin
      fault = FAULT_SHORT;
    end else if (~crc_shadow != hdr_word(20)) begin
      fault = FAULT_CRC;
    end else begin
      fault = FAULT_OK;
    end

    v.slot  = slot;
    v.ok    = (fault == FAULT_OK);
    v.fault = fault;
    if (v.ok) begin
      v.seq = hdr_word(12);
      v.len = LenW'(hdr_word(16));
    end
    // A failed slot loses its record, sequence included.
    slot_live[slot] = v.ok;
    slot_seq[slot]  = v.seq;
    stream_pos      = '0;
    crc_shadow      = CrcInit;

    a_live  = slot_live[0];
    b_live  = slot_live[1];
    b_ahead = seq_is_ahead(slot_seq[1], slot_seq[0]);
    v.any    = a_live | b_live;
    v.newest = (a_live || b_live) && (!a_live || (b_live && b_ahead));
    if (a_live && (!b_live || !b_ahead)) begin
      v.wslot = 1'b1;
      wseq    = slot_seq[0] + 1'b1;
    end else if (b_live) begin
      v.wslot = 1'b0;
      wseq    = slot_seq[1] + 1'b1;
    end else begin
      v.wslot = 1'b0;
      wseq    = 32'd1;
    end
    // Sequence zero is never handed out.
    v.wseq = (wseq == '0) ? 32'd1 : wseq;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus building.
  // ---------------------------------------------------------------------------------------
  function automatic header_t good_header(input logic [31:0] seq, input logic [31:0] len);
    header_t h;
    h.magic    = MagicWord;
    h.version  = VersionWord;
    h.hsize    = 16'(HeaderBytes);
    h.unit     = cfg_unit;
    h.seq      = seq;
    h.len      = len;
    h.crc_flip = '0;
    h.commit   = CommitWord;
    return h;
  endfunction

  // Flips one random bit of one checked header field: magic, version, header size, unit id
  // or commit mark, picked by which.
  function automatic header_t spoil_header(input header_t h, input int unsigned which);
    case (which)
      0:       h.magic   ^= 32'd1 << $urandom_range(0, 31);
      1:       h.version ^= 16'd1 << $urandom_range(0, 15);
      2:       h.hsize   ^= 16'd1 << $urandom_range(0, 15);
      3:       h.unit    ^= 16'd1 << $urandom_range(0, 15);
      default: h.commit  ^= 32'd1 << $urandom_range(0, 31);
    endcase
    return h;
  endfunction

  // Fills slot_image with the header, sent random payload bytes and extra trailing bytes.
  // The CRC field covers the payload bytes within the header's length that are present.
  function automatic void build_image(input header_t h, input int unsigned sent,
                                      input int unsigned extra);
    logic [7:0]   payload [$];
    logic [7:0]   b;
    logic [31:0]  crc;
    logic [255:0] packed_hdr;
    crc = CrcInit;
    for (int unsigned i = 0; i < sent; i++) begin
      b = 8'($urandom);
      if (i < h.len) begin
        crc = crc_step(crc, b);
      end
      payload.push_back(b);
    end
    // The padding after the unit id and the reserved tail carry random bytes.
    packed_hdr = {32'($urandom), h.commit, ~crc ^ h.crc_flip, h.len, h.seq,
                  16'($urandom), h.unit, h.hsize, h.version, h.magic};
    slot_image.delete();
    for (int i = 0; i < HeaderBytes; i++) begin
      slot_image.push_back(packed_hdr[8*i +: 8]);
    end
    foreach (payload[i]) begin
      slot_image.push_back(payload[i]);
    end
    for (int unsigned i = 0; i < extra; i++) begin
      slot_image.push_back(8'($urandom));
    end
  endfunction

  function automatic void cut_image(input int unsigned keep);
    while (slot_image.size() > keep) begin
      void'(slot_image.pop_back());
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Drivers. They are called at a rising edge and return at the edge that completed their
  // transfer; valid is left high so that a following transfer can go on without a gap.
  // ---------------------------------------------------------------------------------------

  // Sends one byte and predicts what it causes. While gaps are on, the sender idles between
  // bursts: once a burst has run out, valid drops before the next byte is offered.
  task automatic push_byte(input logic slot, input logic [7:0] data, input logic last);
    verdict_t v;
    if (gaps_on && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end else if (burst_left != 0) begin
      burst_left--;
    end
    in_valid_i   <= 1'b1;
    slot_index_i <= slot;
    data_byte_i  <= data;
    last_byte_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    if (judge_byte(slot, data, last, v)) begin
      verdicts_due.push_back(v);
    end
  endtask

  // Streams slot_image with the last byte marked. With mix set, every byte but the last
  // carries a random slot index, so only the last one decides the slot.
  task automatic send_image(input logic slot, input logic mix);
    int unsigned n;
    n = slot_image.size();
    for (int unsigned i = 0; i < n; i++) begin
      push_byte((mix && i + 1 < n) ? 1'($urandom_range(0, 1)) : slot, slot_image[i],
                i + 1 == n);
    end
  endtask

  task automatic send_valid(input logic slot, input logic [31:0] seq, input logic [31:0] len);
    build_image(good_header(seq, len), len, 0);
    send_image(slot, 1'b0);
  endtask

  // Lets the block run dry: every predicted verdict taken, plus a short wait for a byte
  // that gave no verdict to settle inside the block.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_UNIT_ID:     cfg_unit = value;
      REG_PAYLOAD_CAP: cfg_cap  = value[LenW-1:0];
      default: ;
    endcase
  endtask

  // Both registers are written back to back only once the block is idle.
  task automatic apply_config(input logic [15:0] unit, input logic [LenW-1:0] cap);
    wait_idle();
    write_reg(REG_UNIT_ID, unit);
    write_reg(REG_PAYLOAD_CAP, CfgDataW'(cap));
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------------------

  // With no record stored the selection outputs take their empty values, and a stream that
  // ends inside the header is reported as too short, whether after one byte or after 31.
  task automatic test_empty_records();
    build_image(good_header(32'd1, 32'd0), 0, 0);
    cut_image(1);
    send_image(1'b0, 1'b0);
    build_image(good_header(32'd1, 32'd0), 0, 0);
    cut_image(HeaderBytes - 1);
    send_image(1'b1, 1'b0);
  endtask

  // Newest-slot and write-slot choice across the sequence wrap: equal sequences, a
  // distance of exactly half the range, the next sequence skipping zero, and a slot that
  // loses its record after a bad CRC.
  task automatic test_slot_selection();
    header_t h;
    send_valid(1'b0, 32'd5, 32'd0);
    send_valid(1'b1, 32'hffff_ffff, 32'd3);
    send_valid(1'b0, 32'hffff_fff0, 32'd1);
    send_valid(1'b0, 32'hffff_ffff, 32'd2);
    send_valid(1'b1, 32'h7fff_ffff, 32'd0);
    h = good_header(32'h1234_5678, 32'd4);
    h.crc_flip = 32'h8000_0000;
    build_image(h, 4, 0);
    send_image(1'b0, 1'b0);
  endtask

  // Each checked header field in turn carries a wrong bit. The last case also changes the
  // slot index within the stream.
  task automatic test_header_faults();
    for (int unsigned which = 0; which < 5; which++) begin
      build_image(spoil_header(good_header(32'd9, 32'd2), which), 2, 0);
      send_image(1'(which), which == 4);
    end
  endtask

  // Length over capacity, a payload cut short, a CRC mismatch, trailing bytes that must be
  // ignored, and a good slot whose bytes arrive under mixed slot indexes.
  task automatic test_length_checks();
    header_t h;
    build_image(good_header(32'd20, 32'(cfg_cap) + 32'd1), 2, 0);
    send_image(1'b1, 1'b0);
    build_image(good_header(32'd21, 32'd8), 4, 0);
    send_image(1'b0, 1'b0);
    h = good_header(32'd22, 32'd3);
    h.crc_flip = 32'd1;
    build_image(h, 3, 0);
    send_image(1'b1, 1'b0);
    build_image(good_header(32'd23, 32'd2), 2, 5);
    send_image(1'b0, 1'b0);
    build_image(good_header(32'd24, 32'd1), 1, 0);
    send_image(1'b1, 1'b1);
  endtask

  // Register extremes: the all-ones unit id with zero capacity, where only an empty
  // payload passes, then a capacity of 4064, where a length equal to the capacity passes the
  // capacity check and a stream that stops early is reported as too short.
  task automatic test_config_extremes();
    apply_config(16'hffff, '0);
    send_valid(1'b0, 32'd40, 32'd0);
    send_valid(1'b1, 32'd41, 32'd1);
    apply_config(16'h5a3c, LenW'(4064));
    build_image(good_header(32'd42, 32'd4064), 4, 0);
    send_image(1'b1, 1'b0);
  endtask

  // Picks a sequence near the other slot's record so that the wrap-safe compare is pushed
  // to its edges, or an extreme or random value otherwise.
  function automatic logic [31:0] pick_seq(input logic slot);
    logic [31:0] other;
    other = slot_seq[~slot];
    case ($urandom_range(0, 5))
      0:       return other + $urandom_range(1, 3);
      1:       return other - $urandom_range(0, 3);
      2:       return other + 32'h8000_0000 - $urandom_range(0, 1);
      3:       return $urandom_range(0, 1) ? 32'hffff_ffff : 32'd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_len();
    int unsigned top;
    top = (cfg_cap < 12) ? cfg_cap : 12;
    if ($urandom_range(0, 9) == 0) begin
      top = (cfg_cap < 48) ? cfg_cap : 48;
    end
    return $urandom_range(0, top);
  endfunction

  // One random stream. Most are well-formed slots with random content; the rest break the
  // header, the length, the payload or the CRC, or are plain noise.
  task automatic random_stream();
    header_t     h;
    logic        slot;
    int unsigned kind;
    slot = $urandom_range(0, 1);
    kind = $urandom_range(0, 99);
    h    = good_header(pick_seq(slot), pick_len());
    if (kind < 55) begin
      build_image(h, h.len, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
    end else if (kind < 62) begin
      build_image(spoil_header(h, $urandom_range(0, 4)), h.len, 0);
    end else if (kind < 68) begin
      h.len = $urandom_range(0, 2) == 0 ? ($urandom | 32'h1000)
                                        : 32'(cfg_cap) + $urandom_range(1, 4);
      build_image(h, $urandom_range(0, 6), 0);
    end else if (kind < 75) begin
      h.crc_flip = 32'd1 << $urandom_range(0, 31);
      build_image(h, h.len, 0);
    end else if (kind < 82) begin
      if (h.len == 0) begin
        h.len = 1;
      end
      build_image(h, $urandom_range(0, h.len - 1), 0);
    end else if (kind < 90) begin
      build_image(h, h.len, 0);
      cut_image($urandom_range(1, HeaderBytes - 1));
    end else begin
      slot_image.delete();
      repeat ($urandom_range(1, 48)) slot_image.push_back(8'($urandom));
    end
    send_image(slot, $urandom_range(0, 9) == 0);
  endtask

  // Four register settings, the extremes among them. One phase runs with no sender gaps.
  // Each phase runs until it has sent a few dozen bytes.
  task automatic test_random_traffic();
    int unsigned start_bytes;
    for (int unsigned phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       apply_config(16'($urandom), LenW'(4064));
        1:       apply_config(16'hffff, '0);
        2:       apply_config(16'h0000, LenW'($urandom_range(1, 20)));
        default: apply_config(16'($urandom), LenW'($urandom_range(21, 4064)));
      endcase
      gaps_on     = (phase != 2);
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < 30) begin
        random_stream();
      end
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------------------
  // Output side: the receiver stalls on a pattern picked at random, from time to time, among
  // never, sometimes, a fixed repeating pattern, and mostly.
  // ---------------------------------------------------------------------------------------
  int unsigned rx_cycle = 0;
  int unsigned rx_mode  = 0;

  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 200 == 0) begin
      rx_mode = $urandom_range(0, 3);
    end
    case (rx_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 99) < 30);
      2:       out_stall_i <= (rx_cycle % 4 != 0);
      default: out_stall_i <= ($urandom_range(0, 99) < 80);
    endcase
  end

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $time, what);
    end
  endfunction

  // Every verdict transfer is matched against the oldest prediction, field by field.
  always @(posedge clk_i) begin : take_verdict
    verdict_t got;
    verdict_t want;
    string    diff;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{result_slot_o, slot_valid_o, fault_e'(fault_code_o), slot_sequence_o,
              payload_length_o, any_valid_o, newest_slot_o, write_slot_o, write_sequence_o};
      if (verdicts_due.size() == 0) begin
        note_mismatch($sformatf("verdict for slot %0d with none expected", got.slot));
      end else begin
        want = verdicts_due.pop_front();
        diff = "";
        if (got.slot !== want.slot)
          diff = {diff, $sformatf(" result_slot exp %0d got %0d", want.slot, got.slot)};
        if (got.ok !== want.ok)
          diff = {diff, $sformatf(" slot_valid exp %0d got %0d", want.ok, got.ok)};
        if (got.fault !== want.fault)
          diff = {diff, $sformatf(" fault_code exp %0d got %0d", want.fault, got.fault)};
        if (got.seq !== want.seq)
          diff = {diff, $sformatf(" slot_sequence exp %h got %h", want.seq, got.seq)};
        if (got.len !== want.len)
          diff = {diff, $sformatf(" payload_length exp %0d got %0d", want.len, got.len)};
        if (got.any !== want.any)
          diff = {diff, $sformatf(" any_valid exp %0d got %0d", want.any, got.any)};
        if (got.newest !== want.newest)
          diff = {diff, $sformatf(" newest_slot exp %0d got %0d", want.newest, got.newest)};
        if (got.wslot !== want.wslot)
          diff = {diff, $sformatf(" write_slot exp %0d got %0d", want.wslot, got.wslot)};
        if (got.wseq !== want.wseq)
          diff = {diff, $sformatf(" write_sequence exp %h got %h", want.wseq, got.wseq)};
        if (diff != "") begin
          note_mismatch({"verdict mismatch:", diff});
        end
      end
    end
  end

  // Watchdog against a block that hangs or never delivers a verdict.
  int unsigned cycles_run = 0;

  always @(posedge clk_i) begin
    cycles_run++;
    if (cycles_run == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // The test sequence. Reset is held from the start and released at a rising edge; the
  // register write tests come after the tests that rely on the reset register values.
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_records();
    test_slot_selection();
    test_header_faults();
    test_length_checks();
    test_config_extremes();
    test_random_traffic();
    wait_idle();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/abjsc_pkg.sv
src/ab_journal_slot_checker.sv
test/ab_journal_slot_checker_tb.sv
